### hdl/urx_pkg.sv
package urx_pkg;

    // Input item modes.
    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // Event codes reported on ticks.
    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_FULL    = 2'd1;
    localparam logic [1:0] EVT_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDLE_TICKS     = 1'b0;
    localparam logic CFG_FULL_THRESHOLD = 1'b1;

    localparam logic [15:0] IDLE_TICKS_RESET     = 16'd10;
    localparam logic [8:0]  FULL_THRESHOLD_RESET = 9'd240;
    localparam logic [8:0]  AVAIL_MAX            = 9'h1ff;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } urx_state_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic exec;
    } urx_cmd_t;

    typedef struct packed {
        logic clear_last;
    } urx_status_t;

endpackage

### hdl/urx_ctrl.sv
module urx_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  urx_pkg::urx_status_t status,
    output urx_pkg::urx_cmd_t    cmd
);

    urx_pkg::urx_state_t state_reg;
    urx_pkg::urx_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= urx_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        // The output register can take a new result when it is empty or is
        // being emptied in this cycle.
        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            urx_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = urx_pkg::S_IDLE;
                end
            end
            urx_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = urx_pkg::S_EXEC;
                end
            end
            urx_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = urx_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = urx_pkg::S_CLEAR;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/urx_dpath.sv
module urx_dpath
#(
    parameter int DEPTH = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  urx_pkg::urx_cmd_t    cmd,
    output urx_pkg::urx_status_t status,
    input  logic [1:0]           mode,
    input  logic [7:0]           rx_byte,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [15:0]          wr_data,
    output logic [7:0]           data,
    output logic                 data_valid,
    output logic [1:0]           event_res,
    output logic [8:0]           avail
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > 9) ? CW : 9;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [8:0]    mem [DEPTH];
    logic [8:0]    rdata_reg;

    logic [15:0]   idle_ticks_reg;
    logic [8:0]    full_threshold_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] write_pos_reg;
    logic [AW-1:0] write_pos_next;
    logic [AW-1:0] head_pos_reg;
    logic [AW-1:0] head_pos_next;
    logic [CW-1:0] held_reg;
    logic [CW-1:0] held_next;
    logic [15:0]   countdown_reg;
    logic [15:0]   countdown_next;
    logic          arrived_reg;
    logic          arrived_next;

    logic [1:0]    mode_reg;
    logic [7:0]    byte_reg;
    logic [AW-1:0] addr_reg;

    logic [7:0]    data_reg;
    logic [7:0]    data_next;
    logic          data_valid_reg;
    logic          data_valid_next;
    logic [1:0]    event_reg;
    logic [1:0]    event_next;
    logic [8:0]    avail_reg;
    logic [8:0]    avail_next;

    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [8:0]    mem_wdata;
    logic [8:0]    thr_eff;

    // A byte goes in at the write position; reads and ticks look at the head.
    assign rd_addr = (mode == urx_pkg::MODE_BYTE) ? write_pos_reg : head_pos_reg;
    assign thr_eff = (full_threshold_reg == '0) ? 9'd1 : full_threshold_reg;
    assign status.clear_last = (clr_addr_reg == AW'(DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            byte_reg <= rx_byte;
            addr_reg <= rd_addr;
        end
        if (cmd.exec)
        begin
            data_reg       <= data_next;
            data_valid_reg <= data_valid_next;
            event_reg      <= event_next;
            avail_reg      <= avail_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg     <= urx_pkg::IDLE_TICKS_RESET;
            full_threshold_reg <= urx_pkg::FULL_THRESHOLD_RESET;
            clr_addr_reg       <= '0;
            write_pos_reg      <= '0;
            head_pos_reg       <= '0;
            held_reg           <= '0;
            countdown_reg      <= '0;
            arrived_reg        <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    urx_pkg::CFG_IDLE_TICKS:     idle_ticks_reg     <= wr_data;
                    urx_pkg::CFG_FULL_THRESHOLD: full_threshold_reg <= wr_data[8:0];
                    default:                     ;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                write_pos_reg <= write_pos_next;
                head_pos_reg  <= head_pos_next;
                held_reg      <= held_next;
                countdown_reg <= countdown_next;
                arrived_reg   <= arrived_next;
            end
        end
    end

    always_comb
    begin
        write_pos_next  = write_pos_reg;
        head_pos_next   = head_pos_reg;
        held_next       = held_reg;
        countdown_next  = countdown_reg;
        arrived_next    = arrived_reg;
        data_next       = '0;
        data_valid_next = 1'b0;
        event_next      = urx_pkg::EVT_NONE;
        mem_we          = cmd.clear_step;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;
        if (cmd.exec)
        begin
            case (mode_reg)
                urx_pkg::MODE_BYTE:
                begin
                    // Overwriting a valid entry replaces the oldest byte and
                    // leaves the count unchanged.
                    if (!rdata_reg[8] && (held_reg < CW'(DEPTH)))
                    begin
                        held_next = held_reg + 1'b1;
                    end
                    mem_we         = 1'b1;
                    mem_waddr      = addr_reg;
                    mem_wdata      = {1'b1, byte_reg};
                    write_pos_next = next_pos(write_pos_reg);
                    arrived_next   = 1'b1;
                end
                urx_pkg::MODE_READ:
                begin
                    if (rdata_reg[8])
                    begin
                        data_next       = rdata_reg[7:0];
                        data_valid_next = 1'b1;
                        mem_we          = 1'b1;
                        mem_waddr       = addr_reg;
                        mem_wdata       = '0;
                        head_pos_next   = next_pos(head_pos_reg);
                        if (held_reg != '0)
                        begin
                            held_next = held_reg - 1'b1;
                        end
                    end
                end
                urx_pkg::MODE_TICK:
                begin
                    if (rdata_reg[8] && (held_reg != '0))
                    begin
                        if (arrived_reg)
                        begin
                            countdown_next = idle_ticks_reg;
                            arrived_next   = 1'b0;
                        end
                        else if (countdown_reg != '0)
                        begin
                            countdown_next = countdown_reg - 1'b1;
                        end
                        if (MW'(held_reg) >= MW'(thr_eff))
                        begin
                            event_next = urx_pkg::EVT_FULL;
                        end
                        else if (countdown_next == '0)
                        begin
                            event_next = urx_pkg::EVT_TIMEOUT;
                        end
                    end
                    else
                    begin
                        countdown_next = '0;
                        arrived_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        avail_next = (MW'(held_next) > MW'(urx_pkg::AVAIL_MAX)) ? urx_pkg::AVAIL_MAX
                                                                : 9'(held_next);
    end

    assign data       = data_reg;
    assign data_valid = data_valid_reg;
    assign event_res  = event_reg;
    assign avail      = avail_reg;

endmodule

### hdl/uart_rx_ring_idle_timeout.sv
// An accepted item's ring entry is read into a register in the idle state; the exec state's
// update then loads its result into the output register, and a stalled result holds the update.
// No new item is taken until the previous one is written back, as the ring memory is updated
// by read-modify-write (registered read, then update and write-back).
// Reset: asynchronous, active low; afterwards a clearing pass writes every ring entry in turn to
// mark it invalid, during which no item is accepted. Configuration writes are always taken.
module uart_rx_ring_idle_timeout
#(
    parameter int DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data,
    output logic        data_valid,
    output logic [1:0]  event_res,
    output logic [8:0]  avail,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [15:0] wr_data
);

    urx_pkg::urx_cmd_t    cmd;
    urx_pkg::urx_status_t status;

    urx_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    urx_dpath #(.DEPTH(DEPTH)) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .data       (data),
        .data_valid (data_valid),
        .event_res  (event_res),
        .avail      (avail)
    );

endmodule

### hdl/urx_checker.sv
module urx_checker
#(
    parameter int DEPTH = 256
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data,
    input logic       data_valid,
    input logic [1:0] event_res,
    input logic [8:0] avail
);

    // A read that returns a byte is never a tick, so it carries no event.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> event_res == urx_pkg::EVT_NONE)
        else $error("event reported alongside a returned byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> data == 8'd0)
        else $error("nonzero data without data_valid");

    // Each item occupies the ring until its update is done, so the next one waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while the previous one is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(avail) <= DEPTH) || (avail == urx_pkg::AVAIL_MAX))
        else $error("avail exceeds the ring depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data) && $stable(avail))
        else $error("stalled result changed");

endmodule

bind uart_rx_ring_idle_timeout urx_checker #(.DEPTH(DEPTH)) u_urx_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data       (data),
    .data_valid (data_valid),
    .event_res  (event_res),
    .avail      (avail)
);
